[src/sms_pkg.sv]
package sms_pkg;

    localparam int LEN_W               = 5;
    localparam int CFG_W               = 64;
    localparam int PATTERN_BYTES       = 16;
    localparam int PATTERN_IDX_W       = $clog2(PATTERN_BYTES);
    localparam int POS_W               = 16;
    localparam int CFG_IDX_W           = 2;
    localparam int DEFAULT_MAX_PATTERN = 16;
    localparam longint unsigned DEFAULT_MAX_TEXT = 64'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    typedef struct packed {
        logic shift;
        logic in_use;
    } cell_ctl_t;

    // pattern byte that lines up with window cell k for the given length
    function automatic logic [7:0] expected_byte(
        input logic [8*PATTERN_BYTES-1:0] pattern,
        input logic [LEN_W-1:0]           used_len,
        input int                         k
    );
        logic [LEN_W-1:0] d;
        d = used_len - LEN_W'(1) - LEN_W'(k);
        return pattern[8*d[PATTERN_IDX_W-1:0] +: 8];
    endfunction

endpackage

[src/sms_cell.sv]
module sms_cell (
    input  logic              clk,
    input  sms_pkg::cell_ctl_t ctl,
    input  logic [7:0]        shift_in,
    input  logic [7:0]        expected,
    output logic [7:0]        byte_q,
    output logic              hit
);
    import sms_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = ctl.shift ? shift_in : byte_reg;

    // compare against the window as it stands after this transaction
    assign hit    = !ctl.in_use || (byte_next == expected);
    assign byte_q = byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

[src/substring_match_scanner.sv]
// Substring scanner: text bytes stream in one per cycle through a row of
// MAX_PATTERN byte cells, each comparing its byte against the matching
// pattern byte, so a match ending at the newest byte is known in the same
// cycle it is taken. An item with end_of_text loads one result into the
// output register and clears the per-text state; the next text may start in
// the following cycle. Throughput is one item per cycle, set by the cell row
// compare plus the position bookkeeping in a single stage; an end item waits
// only while an earlier result is still held at the output by out_stall.
// Bytes past MAX_TEXT are dropped and flagged as too_long. The user must write
// configuration via cfg_write/cfg_index/cfg_data only while no text is active; not checked.
module substring_match_scanner #(
    parameter int              MAX_PATTERN = sms_pkg::DEFAULT_MAX_PATTERN,
    parameter longint unsigned MAX_TEXT    = sms_pkg::DEFAULT_MAX_TEXT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [sms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sms_pkg::CFG_W-1:0]     cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    text_byte,
    input  logic                          byte_present,
    input  logic                          end_of_text,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          first_found,
    output logic [sms_pkg::POS_W-1:0]     first_position,
    output logic                          last_found,
    output logic [sms_pkg::POS_W-1:0]     last_position,
    output logic                          starts_with,
    output logic                          ends_with,
    output logic                          too_long
);
    import sms_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT + 64'd1);
    localparam int CMP_W = CNT_W + LEN_W;

    // configuration
    logic [LEN_W-1:0]             pattern_length_reg;
    logic [CFG_W-1:0]             pattern_low_reg;
    logic [CFG_W-1:0]             pattern_high_reg;
    logic [8*PATTERN_BYTES-1:0]   pattern;
    logic [LEN_W-1:0]             used_len;

    // per-text state
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         seen_reg;
    logic                         seen_next;
    logic                         starts_reg;
    logic                         starts_next;
    logic                         over_reg;
    logic                         over_next;
    logic [POS_W-1:0]             earliest_reg;
    logic [POS_W-1:0]             earliest_next;
    logic [POS_W-1:0]             latest_reg;
    logic [POS_W-1:0]             latest_next;

    // result register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         first_found_reg;
    logic [POS_W-1:0]             first_position_reg;
    logic [POS_W-1:0]             last_position_reg;
    logic                         starts_with_reg;
    logic                         ends_with_reg;
    logic                         too_long_reg;

    logic                         in_accept;
    logic                         out_accept;
    logic                         full;
    logic                         take;
    logic [CNT_W-1:0]             count_after;
    logic                         enough;
    logic                         window_ok;
    logic                         match_now;
    logic [CNT_W-1:0]             start;
    logic [CNT_W+POS_W-1:0]       start_ext;
    logic [POS_W-1:0]             start_pos;
    logic                         seen_after;
    logic                         starts_after;
    logic                         over_after;
    logic [POS_W-1:0]             earliest_after;
    logic [POS_W-1:0]             latest_after;

    cell_ctl_t                    ctl [MAX_PATTERN];
    logic [7:0]                   win [MAX_PATTERN];
    logic [7:0]                   expected [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]       hit;

    assign pattern  = {pattern_high_reg, pattern_low_reg};
    assign used_len = (pattern_length_reg > LEN_W'(MAX_PATTERN)) ?
                      LEN_W'(MAX_PATTERN) : pattern_length_reg;

    assign in_stall   = out_valid_reg && out_stall && end_of_text;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign full = (count_reg >= CNT_W'(MAX_TEXT));
    assign take = in_accept && byte_present && !full;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            assign ctl[k].shift  = take;
            assign ctl[k].in_use = (LEN_W'(k) < used_len);
            assign expected[k]   = expected_byte(pattern, used_len, k);

            if (k == 0)
            begin : g_head
                sms_cell u_cell (
                    .clk      (clk),
                    .ctl      (ctl[k]),
                    .shift_in (text_byte),
                    .expected (expected[k]),
                    .byte_q   (win[k]),
                    .hit      (hit[k])
                );
            end
            else
            begin : g_body
                sms_cell u_cell (
                    .clk      (clk),
                    .ctl      (ctl[k]),
                    .shift_in (win[k-1]),
                    .expected (expected[k]),
                    .byte_q   (win[k]),
                    .hit      (hit[k])
                );
            end
        end
    endgenerate

    assign count_after = take ? count_reg + CNT_W'(1) : count_reg;
    assign enough      = (CMP_W'(count_after) >= CMP_W'(used_len));
    assign window_ok   = enough && (&hit);
    assign match_now   = take && ((used_len == '0) || window_ok);

    assign start     = (used_len == '0) ? count_reg : count_after - CNT_W'(used_len);
    assign start_ext = {{POS_W{1'b0}}, start};
    assign start_pos = start_ext[POS_W-1:0];

    assign seen_after     = seen_reg || match_now;
    assign starts_after   = starts_reg || (match_now && (start == '0));
    assign over_after     = over_reg || (in_accept && byte_present && full);
    assign earliest_after = (match_now && !seen_reg) ? start_pos : earliest_reg;
    assign latest_after   = match_now ? start_pos : latest_reg;

    always_comb
    begin
        count_next     = count_reg;
        seen_next      = seen_reg;
        starts_next    = starts_reg;
        over_next      = over_reg;
        earliest_next  = earliest_reg;
        latest_next    = latest_reg;
        out_valid_next = out_valid_reg && !out_accept;
        if (in_accept)
        begin
            if (end_of_text)
            begin
                count_next     = '0;
                seen_next      = 1'b0;
                starts_next    = 1'b0;
                over_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                count_next    = count_after;
                seen_next     = seen_after;
                starts_next   = starts_after;
                over_next     = over_after;
                earliest_next = earliest_after;
                latest_next   = latest_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            count_reg          <= '0;
            seen_reg           <= 1'b0;
            starts_reg         <= 1'b0;
            over_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                    CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                    default:            ;
                endcase
            end
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            starts_reg    <= starts_next;
            over_reg      <= over_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // positions are only visible once a match is seen
    always_ff @(posedge clk)
    begin
        earliest_reg <= earliest_next;
        latest_reg   <= latest_next;
        if (in_accept && end_of_text)
        begin
            first_found_reg    <= seen_after;
            first_position_reg <= seen_after ? earliest_after : '0;
            last_position_reg  <= seen_after ? latest_after : '0;
            starts_with_reg    <= (used_len == '0) || starts_after;
            ends_with_reg      <= (used_len == '0) || window_ok;
            too_long_reg       <= over_after;
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_found    = first_found_reg;
    assign first_position = first_position_reg;
    assign last_found     = first_found_reg;
    assign last_position  = last_position_reg;
    assign starts_with    = starts_with_reg;
    assign ends_with      = ends_with_reg;
    assign too_long       = too_long_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import sms_pkg::*;

    localparam int          LONG_HOLD  = 120;
    localparam int unsigned CYCLE_CAP  = 1000000;
    localparam int          LONG_TEXT  = 65556;

    typedef struct packed {
        logic             first_found;
        logic [POS_W-1:0] first_position;
        logic             last_found;
        logic [POS_W-1:0] last_position;
        logic             starts_with;
        logic             ends_with;
        logic             too_long;
    } scan_result_t;

    typedef struct packed {
        logic             cfg;
        logic [LEN_W-1:0] len;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [7:0]       text;
        logic             present;
        logic             last;
        logic             typed;
        scan_result_t     want;
    } dir_row_t;

    localparam scan_result_t NO_RES = '0;

    // cfg, len, low bytes, high bytes, byte, present, end, typed, expected
    localparam dir_row_t DIRECTED [19] = '{
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1,
          {1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b1,
          {1'b1, 16'd0, 1'b1, 16'd1, 1'b1, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'hAA, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b1, 5'd2,  64'h6261, 64'h0, 8'h55, 1'b0, 1'b1, 1'b1,
          {1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h61, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h62, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h61, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h62, 1'b1, 1'b1, 1'b1,
          {1'b1, 16'd0, 1'b1, 16'd2, 1'b1, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h61, 1'b1, 1'b1, 1'b1,
          {1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h78, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h61, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h62, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h78, 1'b1, 1'b1, 1'b0, NO_RES},
        '{1'b1, 5'd2,  64'h0, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1,
          {1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1,
          {1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 1'b1, 1'b0}},
        '{1'b1, 5'd31, {64{1'b1}}, {64{1'b1}}, 8'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 5'd0,  64'h0, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b0, NO_RES}
    };

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_PATTERN_LENGTH;
    logic [CFG_W-1:0]     cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [7:0]           text_byte      = 8'h00;
    logic                 byte_present   = 1'b0;
    logic                 end_of_text    = 1'b0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 first_found;
    logic [POS_W-1:0]     first_position;
    logic                 last_found;
    logic [POS_W-1:0]     last_position;
    logic                 starts_with;
    logic                 ends_with;
    logic                 too_long;

    substring_match_scanner DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_byte      (text_byte),
        .byte_present   (byte_present),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .first_found    (first_found),
        .first_position (first_position),
        .last_found     (last_found),
        .last_position  (last_position),
        .starts_with    (starts_with),
        .ends_with      (ends_with),
        .too_long       (too_long)
    );

    // scanner copy: configuration and per-text state
    logic [LEN_W-1:0]  pat_len_m = '0;
    logic [CFG_W-1:0]  pat_lo_m  = '0;
    logic [CFG_W-1:0]  pat_hi_m  = '0;
    logic [7:0]        win_m [16];
    longint unsigned   seen_m    = 0;
    int unsigned       first_m   = 0;
    int unsigned       last_m    = 0;
    logic              hit_m     = 1'b0;
    logic              begins_m  = 1'b0;
    logic              over_m    = 1'b0;

    scan_result_t      pending_reports [$];
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_requests  = 0;
    int                mismatches     = 0;
    int                items_sent     = 0;
    int                texts_checked  = 0;
    int                texts_matched  = 0;
    scan_result_t      got_res;
    scan_result_t      want_res;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned used_len();
        int unsigned l;
        l = pat_len_m;
        return (l > PATTERN_BYTES) ? PATTERN_BYTES : l;
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned k);
        logic [CFG_W-1:0] w;
        w = (k < 8) ? pat_lo_m : pat_hi_m;
        return w[8*(k%8) +: 8];
    endfunction

    function automatic logic window_hit(input int unsigned len);
        if (seen_m < len)
            return 1'b0;
        for (int unsigned j = 0; j < len; j++)
        begin
            if (win_m[len-1-j] != pat_byte(j))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_text();
        foreach (win_m[k])
            win_m[k] = 8'h00;
        seen_m   = 0;
        first_m  = 0;
        last_m   = 0;
        hit_m    = 1'b0;
        begins_m = 1'b0;
        over_m   = 1'b0;
    endtask

    task automatic advance_scan(input logic [7:0] b, input logic p, input logic e,
                                input logic typed, input scan_result_t typed_res);
        int unsigned  len;
        int unsigned  start;
        scan_result_t r;
        len = used_len();
        if (p)
        begin
            if (seen_m >= DEFAULT_MAX_TEXT)
                over_m = 1'b1;
            else
            begin
                for (int k = 15; k > 0; k--)
                    win_m[k] = win_m[k-1];
                win_m[0] = b;
                seen_m++;
                if (len == 0 || window_hit(len))
                begin
                    start = (len == 0) ? int'(seen_m - 1) : int'(seen_m - len);
                    if (!hit_m)
                        first_m = start;
                    last_m   = start;
                    hit_m    = 1'b1;
                    if (start == 0)
                        begins_m = 1'b1;
                end
            end
        end
        if (e)
        begin
            r.first_found    = hit_m;
            r.first_position = hit_m ? POS_W'(first_m) : '0;
            r.last_found     = hit_m;
            r.last_position  = hit_m ? POS_W'(last_m) : '0;
            r.starts_with    = (len == 0) || begins_m;
            r.ends_with      = (len == 0) || window_hit(len);
            r.too_long       = over_m;
            pending_reports.push_back(typed ? typed_res : r);
            clear_text();
        end
    endtask

    task automatic send_txn(input logic [7:0] b, input logic p, input logic e,
                            input logic typed = 1'b0, input scan_result_t want = '0);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        text_byte    <= b;
        byte_present <= p;
        end_of_text  <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_scan(b, p, e, typed, want);
        if (p || e)
            items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [LEN_W-1:0] len,
                               input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= {59'({$urandom, $urandom}), len};
        @(posedge clk);
        cfg_index <= CFG_PATTERN_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_PATTERN_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        pat_len_m = len;
        pat_lo_m  = lo;
        pat_hi_m  = hi;
    endtask

    task automatic pick_config(input int kind);
        logic [LEN_W-1:0]   len;
        logic [8*16-1:0]    bytes;
        logic [7:0]         sym_a;
        logic [7:0]         sym_b;
        logic               two_sym;
        sym_a   = 8'($urandom_range(255));
        sym_b   = 8'($urandom_range(255));
        two_sym = ($urandom_range(1) == 1);
        for (int k = 0; k < 16; k++)
            bytes[8*k +: 8] = two_sym ? ($urandom_range(1) ? sym_a : sym_b)
                                      : 8'($urandom_range(255));
        case (kind % 6)
            0:       begin len = 5'd0; bytes = '0; end
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       begin len = 5'd31; bytes = '1; end
            4:       len = LEN_W'($urandom_range(8, 2));
            default: len = LEN_W'($urandom_range(15, 9));
        endcase
        load_config(len, bytes[63:0], bytes[127:64]);
    endtask

    // pattern copies, cut copies and noise, ended on a byte or by a marker
    task automatic send_text(input int max_len, inout int count);
        logic [7:0]  body [$];
        int unsigned len;
        int unsigned n;
        int unsigned cut;
        logic        marker;
        len = used_len();
        n = ($urandom_range(19) == 0) ? 0 : $urandom_range(max_len, 1);
        while (body.size() < n)
        begin
            if (len > 0 && $urandom_range(99) < 35)
            begin
                cut = ($urandom_range(4) == 0) ? $urandom_range(len, 1) : len;
                for (int unsigned j = 0; j < cut; j++)
                    body.push_back(pat_byte(j));
            end
            else if ($urandom_range(1))
                body.push_back(pat_byte($urandom_range(15)));
            else
                body.push_back(8'($urandom_range(255)));
        end
        marker = (body.size() == 0) || ($urandom_range(1) == 1);
        foreach (body[i])
        begin
            if ($urandom_range(11) == 0)
                send_txn(8'($urandom_range(255)), 1'b0, 1'b0);
            send_txn(body[i], 1'b1, !marker && (i == body.size() - 1));
        end
        if (marker)
            send_txn(8'($urandom_range(255)), 1'b0, 1'b1);
        count += body.size() + int'(marker);
    endtask

    task automatic run_texts(input int n_items, input int max_len);
        int count;
        count = 0;
        while (count < n_items)
            send_text(max_len, count);
    endtask

    task automatic flag_mismatch(input string what, input scan_result_t want,
                                 input scan_result_t got);
        if (mismatches < 10)
        begin
            $display("mismatch (%s) at %0t", what, $time);
            $display("  expected ff=%0b fp=%0d lf=%0b lp=%0d sw=%0b ew=%0b tl=%0b",
                     want.first_found, want.first_position, want.last_found,
                     want.last_position, want.starts_with, want.ends_with, want.too_long);
            $display("  got      ff=%0b fp=%0d lf=%0b lp=%0d sw=%0b ew=%0b tl=%0b",
                     got.first_found, got.first_position, got.last_found,
                     got.last_position, got.starts_with, got.ends_with, got.too_long);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = {first_found, first_position, last_found, last_position,
                       starts_with, ends_with, too_long};
            if (pending_reports.size() == 0)
                flag_mismatch("no transaction expected", NO_RES, got_res);
            else
            begin
                want_res = pending_reports.pop_front();
                if (got_res !== want_res)
                    flag_mismatch("field", want_res, got_res);
            end
            texts_checked++;
            if (got_res.first_found === 1'b1)
                texts_matched++;
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] b;
        logic [7:0] syms [3];
        int         modes_send [4];
        int         modes_recv [4];
        modes_send = '{0, 47, 0, 27};
        modes_recv = '{0, 0, 47, 27};
        clear_text();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].cfg)
            begin
                settle();
                load_config(DIRECTED[i].len, DIRECTED[i].lo, DIRECTED[i].hi);
            end
            send_txn(DIRECTED[i].text, DIRECTED[i].present, DIRECTED[i].last,
                     DIRECTED[i].typed, DIRECTED[i].want);
        end

        // one text past the size limit, a match ending on the last kept byte
        settle();
        foreach (syms[k])
            syms[k] = 8'($urandom_range(255));
        load_config(5'd3, {40'h0, syms[2], syms[1], syms[0]}, 64'h0);
        for (int i = 0; i < LONG_TEXT; i++)
        begin
            if (i >= 65533 && i < 65536)
                b = syms[i-65533];
            else
                b = syms[$urandom_range(2)];
            send_txn(b, 1'b1, i == LONG_TEXT - 1);
        end

        for (int m = 0; m < 4; m++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                settle();
                send_idle_pct  = modes_send[m];
                recv_stall_pct = modes_recv[m];
                pick_config(m * 3 + s);
                run_texts(110, 12 + 2 * used_len());
            end
        end

        // fill up behind a long output hold, then drain before going on
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pick_config(4);
        hold_requests++;
        run_texts(30, 4);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        run_texts(20, 8);

        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d text results (%0d with a match) from %0d byte transactions",
                 texts_checked, texts_matched, items_sent);
        $display("pattern lengths 0 to 16 and above, one text past the size limit, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/sms_pkg.sv
src/sms_cell.sv
src/substring_match_scanner.sv
dv/testbench.sv
